// ===== sv/edm_pkg.sv =====
// edm_pkg: shared types for the elgamal decryption core
// no dependencies
package edm_pkg;

	typedef enum logic [1:0] {
		REG_MODULUS  = 2'd0,
		REG_PRIV_EXP = 2'd1
	} reg_idx_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED1,
		ST_RED2,
		ST_EXP_START,
		ST_MUL_ISSUE,
		ST_MUL_WAIT,
		ST_SQR_ISSUE,
		ST_SQR_WAIT,
		ST_EXP_NEXT,
		ST_FINAL_ISSUE,
		ST_FINAL_WAIT,
		ST_OUT
	} state_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_RED1,
		OP_RED2,
		OP_EXP1_INIT,
		OP_EXP2_INIT,
		OP_MUL_START,
		OP_SHIFT
	} op_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MSEL_ACC_BASE,
		MSEL_BASE_BASE,
		MSEL_C2_ACC
	} msel_t;

	// multiplier destination
	typedef enum logic [1:0] {
		MDST_ACC,
		MDST_BASE,
		MDST_OUT
	} mdst_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		mdst_t mdst;
		logic  mul_go;
		logic  red_go;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic red_done;
		logic exp_zero;
		logic exp_bit;
		logic mod_small;
	} dp_status_t;

endpackage

// ===== sv/edm_modmul.sv =====
// edm_modmul: bit-serial shift-and-add modular multiplier and reducer
// depends on nothing but its parameter
module edm_modmul #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         red,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic [W-1:0] result,
	output logic         done
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]    acc_q;
	logic [W:0]    a_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          red_q;
	logic          done_q;
	logic [W+1:0]  sum;
	logic [W:0]    acc_n;
	logic [W+1:0]  dbl;
	logic [W:0]    a_n;
	logic [W+1:0]  sh;
	logic [W:0]    sh_n;

	// product step: add a when the low bit of b is set, then double a
	always_comb begin
		sum   = {1'b0, acc_q} + {1'b0, a_q};
		acc_n = acc_q;
		if (b_q[0])
			acc_n = (sum >= {2'b0, m}) ? sum[W:0] - {1'b0, m} : sum[W:0];
		dbl = {a_q, 1'b0};
		a_n = (dbl >= {2'b0, m}) ? dbl[W:0] - {1'b0, m} : dbl[W:0];
		// restoring reduction step: shift one bit of b into the remainder
		sh   = {acc_q, b_q[W-1]};
		sh_n = (sh >= {2'b0, m}) ? sh[W:0] - {1'b0, m} : sh[W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			red_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				red_q  <= red;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {1'b0, a};
			b_q   <= b;
		end else if (busy_q) begin
			if (red_q) begin
				acc_q <= sh_n;
				b_q   <= {b_q[W-2:0], 1'b0};
			end else begin
				acc_q <= acc_n;
				a_q   <= a_n;
				b_q   <= {1'b0, b_q[W-1:1]};
			end
		end
	end

	assign result = acc_q[W-1:0];
	assign done   = done_q;

endmodule

// ===== sv/edm_datapath.sv =====
// edm_datapath: operand registers, exponent shifter and the shared multiplier
// depends on edm_pkg and edm_modmul
module edm_datapath #(
	parameter int W = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  edm_pkg::dp_cmd_t     cmd,
	input  logic [W-1:0]         modulus,
	input  logic [W-1:0]         private_exponent,
	input  logic [W-1:0]         cipher_first,
	input  logic [W-1:0]         cipher_second,
	output edm_pkg::dp_status_t  status,
	output logic [W-1:0]         plain_value
);
	import edm_pkg::*;

	logic [W-1:0] c1_q, c2_q, acc_q, base_q, exp_q, out_q, p_q;
	logic [W-1:0] ma, mb, mres, red_in;
	logic         mdone;

	// operand selection
	always_comb begin
		case (cmd.msel)
			MSEL_ACC_BASE:  begin ma = acc_q;  mb = base_q; end
			MSEL_BASE_BASE: begin ma = base_q; mb = base_q; end
			MSEL_C2_ACC:    begin ma = c2_q;   mb = acc_q;  end
			default:        begin ma = acc_q;  mb = base_q; end
		endcase
		// c2 reduction is issued in the cycle the c1 reduction completes
		red_in = (cmd.op == OP_RED1 && mdone) ? c2_q : c1_q;
	end

	edm_modmul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_go | cmd.red_go),
		.red    (cmd.red_go),
		.a      (ma),
		.b      (cmd.red_go ? red_in : mb),
		.m      (p_q),
		.result (mres),
		.done   (mdone)
	);

	// register updates
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				c1_q <= cipher_first;
				c2_q <= cipher_second;
				p_q  <= modulus;
			end
			OP_EXP1_INIT: begin
				acc_q  <= W'(1);
				base_q <= c1_q;
				exp_q  <= private_exponent;
			end
			OP_EXP2_INIT: begin
				base_q <= acc_q;
				acc_q  <= W'(1);
				exp_q  <= p_q - W'(2);
			end
			OP_SHIFT: exp_q <= {1'b0, exp_q[W-1:1]};
			default: ;
		endcase
		if (mdone) begin
			if (cmd.op == OP_RED1)
				c1_q <= mres;
			else if (cmd.op == OP_RED2)
				c2_q <= mres;
			else begin
				case (cmd.mdst)
					MDST_ACC:  acc_q  <= mres;
					MDST_BASE: base_q <= mres;
					MDST_OUT:  out_q  <= mres;
					default: ;
				endcase
			end
		end
		if (cmd.op == OP_LOAD && modulus < W'(2))
			out_q <= '0;
	end

	assign status.mul_done  = mdone;
	assign status.red_done  = mdone;
	assign status.exp_zero  = (exp_q == '0);
	assign status.exp_bit   = exp_q[0];
	assign status.mod_small = (p_q < W'(2));
	assign plain_value      = out_q;

endmodule

// ===== sv/edm_ctrl.sv =====
// edm_ctrl: sequencer for reduction, two exponentiations and final product
// depends on edm_pkg
module edm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_ready,
	input  edm_pkg::dp_status_t status,
	output edm_pkg::dp_cmd_t    cmd,
	output logic                in_ready,
	output logic                out_valid
);
	import edm_pkg::*;

	state_t state_q, state_d;
	logic   phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		cmd        = '{op: OP_NONE, msel: MSEL_ACC_BASE, mdst: MDST_ACC,
			mul_go: 1'b0, red_go: 1'b0};
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.op  = OP_LOAD;
					state_d = ST_RED1;
				end
			end
			ST_RED1: begin
				if (status.mod_small)
					state_d = ST_OUT;
				else begin
					cmd.red_go = 1'b1;
					cmd.op     = OP_RED1;
					state_d    = ST_RED2;
				end
			end
			ST_RED2: begin
				cmd.op = OP_RED1;
				if (status.red_done) begin
					cmd.red_go = 1'b1;
					state_d    = ST_EXP_START;
				end
			end
			ST_EXP_START: begin
				cmd.op = OP_RED2;
				if (status.red_done) begin
					state_d = ST_MUL_ISSUE;
					phase_d = 1'b0;
				end
			end
			ST_MUL_ISSUE: begin
				// each pass sets up the exponent registers, the first from c1 and x, the second from p-2
				cmd.op  = phase_q ? OP_EXP2_INIT : OP_EXP1_INIT;
				state_d = ST_EXP_NEXT;
			end
			ST_EXP_NEXT: begin
				if (status.exp_zero) begin
					if (phase_q)
						state_d = ST_FINAL_ISSUE;
					else begin
						phase_d = 1'b1;
						state_d = ST_MUL_ISSUE;
					end
				end else if (status.exp_bit) begin
					cmd.mul_go = 1'b1;
					cmd.msel   = MSEL_ACC_BASE;
					state_d    = ST_MUL_WAIT;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.msel   = MSEL_BASE_BASE;
					state_d    = ST_SQR_WAIT;
				end
			end
			ST_MUL_WAIT: begin
				cmd.mdst = MDST_ACC;
				if (status.mul_done)
					state_d = ST_SQR_ISSUE;
			end
			ST_SQR_ISSUE: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = MSEL_BASE_BASE;
				state_d    = ST_SQR_WAIT;
			end
			ST_SQR_WAIT: begin
				cmd.mdst = MDST_BASE;
				if (status.mul_done) begin
					cmd.op  = OP_SHIFT;
					state_d = ST_EXP_NEXT;
				end
			end
			ST_FINAL_ISSUE: begin
				cmd.mul_go = 1'b1;
				cmd.msel   = MSEL_C2_ACC;
				state_d    = ST_FINAL_WAIT;
			end
			ST_FINAL_WAIT: begin
				cmd.mdst = MDST_OUT;
				if (status.mul_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// input is taken only when idle
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == ST_IDLE)
		else $error("transaction accepted while busy");
	// result is never offered while input is accepted
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("ready and valid both high");
	// a pending result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");

endmodule

// ===== sv/elgamal_decrypt_modexp_core.sv =====
// ElGamal decryption core: m = c2 * (c1^x)^(p-2) mod p. One transaction at a
// time; a ciphertext is first reduced mod p, then up to 4*W+1 modular multiplies
// follow (two square-and-multiply passes plus the final product), all on the one
// bit-serial shift-and-add multiplier. The user must write the registers through
// cfg_we/cfg_index/cfg_data only while idle; the core itself does not enforce it.
// depends on edm_pkg, edm_ctrl, edm_datapath, edm_modmul
module elgamal_decrypt_modexp_core #(
	parameter int MOD_WIDTH = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [MOD_WIDTH-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MOD_WIDTH-1:0] cipher_first,
	input  logic [MOD_WIDTH-1:0] cipher_second,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MOD_WIDTH-1:0] plain_value
);
	import edm_pkg::*;

	logic [MOD_WIDTH-1:0] modulus_q, priv_exp_q;
	dp_cmd_t              cmd;
	dp_status_t           status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_WIDTH'(3);
			priv_exp_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODULUS[0])
				modulus_q <= cfg_data;
			else
				priv_exp_q <= cfg_data;
		end
	end

	edm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_valid & in_ready),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	edm_datapath #(.W(MOD_WIDTH)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.modulus          (modulus_q),
		.private_exponent (priv_exp_q),
		.cipher_first     (cipher_first),
		.cipher_second    (cipher_second),
		.status           (status),
		.plain_value      (plain_value)
	);

endmodule
